### sv/mvc_pkg.sv
package mvc_pkg;

  localparam int MAX_ITEMS   = 1024;
  localparam int VALUE_WIDTH = 32;
  localparam int ADDR_W      = $clog2(MAX_ITEMS);
  localparam int CNT_W       = ADDR_W + 1;

  typedef logic signed [VALUE_WIDTH-1:0] value_t;
  typedef logic [CNT_W-1:0]              count_t;
  typedef logic [ADDR_W-1:0]             addr_t;

  typedef enum logic [1:0] {
    STATUS_FOUND    = 2'd0,
    STATUS_NONE     = 2'd1,
    STATUS_OVERFLOW = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_LOAD   = 2'd0,
    ST_SCAN   = 2'd1,
    ST_RESULT = 2'd2
  } state_t;

endpackage

### sv/mvc_in_if.sv
interface mvc_in_if;
  logic                 valid;
  logic                 ready;
  mvc_pkg::value_t      value;
  logic                 last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

### sv/mvc_out_if.sv
interface mvc_out_if;
  logic                 valid;
  logic                 ready;
  mvc_pkg::value_t      majority_value;
  logic [1:0]           status;

  modport source (output valid, output majority_value, output status, input ready);
  modport sink   (input valid, input majority_value, input status, output ready);
endinterface

### sv/mvc_ram.sv
module mvc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### sv/majority_vote_with_check.sv
// Majority vote over a frame of signed values. Items are taken one per cycle while
// the block loads a frame: each is written, while room remains, to a 1024-entry buffer
// and fed to a running Boyer-Moore vote. After the request marked last, the buffer is
// replayed through its single read port to count the candidate, and the result is then
// posted; input is not ready during the replay or until the result is posted. The single
// result reports the candidate with status found when it occurs in more than half of the
// frame, 0 with status no-majority otherwise, and 0 with status overflow for a frame
// longer than 1024 items (no replay).
module majority_vote_with_check (
  input  logic             clk,
  input  logic             rst_n,
  mvc_in_if.sink           in_ch,
  mvc_out_if.source        out_ch
);

  mvc_pkg::state_t  state_r, state_nxt;
  mvc_pkg::value_t  cand_r, cand_nxt;
  mvc_pkg::count_t  vote_r, vote_nxt;
  mvc_pkg::count_t  items_r, items_nxt;
  logic             ovf_r, ovf_nxt;
  mvc_pkg::count_t  scan_r, scan_nxt;
  logic             rd_pend_r, rd_pend_nxt;
  mvc_pkg::count_t  hits_r, hits_nxt;
  logic             out_valid_r, out_valid_nxt;
  mvc_pkg::value_t  out_value_r, out_value_nxt;
  mvc_pkg::status_t out_status_r, out_status_nxt;

  logic             accept;
  logic             full;
  logic             wr_en;
  mvc_pkg::value_t  rd_data;
  logic             match;
  logic             match_a;
  mvc_pkg::value_t  match_b;
  logic             out_free;

  // frame buffer
  mvc_ram #(
    .WIDTH (mvc_pkg::VALUE_WIDTH),
    .DEPTH (mvc_pkg::MAX_ITEMS)
  ) u_buf (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (items_r[mvc_pkg::ADDR_W-1:0]),
    .wr_data (in_ch.value),
    .rd_addr (scan_r[mvc_pkg::ADDR_W-1:0]),
    .rd_data (rd_data)
  );

  assign in_ch.ready   = (state_r == mvc_pkg::ST_LOAD);
  assign accept        = in_ch.valid && in_ch.ready;
  assign full          = (items_r == mvc_pkg::count_t'(mvc_pkg::MAX_ITEMS));
  assign wr_en         = accept && !full;
  assign out_free      = !out_valid_r || out_ch.ready;

  // shared equality compare: incoming value while loading, buffer data while scanning
  assign match_b       = (state_r == mvc_pkg::ST_LOAD) ? in_ch.value : rd_data;
  assign match         = (match_b == cand_r);
  assign match_a       = match;

  assign out_ch.valid          = out_valid_r;
  assign out_ch.majority_value = out_value_r;
  assign out_ch.status         = out_status_r;

  // sequencer: load, replay, post result
  always_comb begin
    state_nxt      = state_r;
    cand_nxt       = cand_r;
    vote_nxt       = vote_r;
    items_nxt      = items_r;
    ovf_nxt        = ovf_r;
    scan_nxt       = scan_r;
    rd_pend_nxt    = 1'b0;
    hits_nxt       = hits_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;

    case (state_r)
      mvc_pkg::ST_LOAD: begin
        if (accept) begin
          // store or flag overflow
          if (full) begin
            ovf_nxt = 1'b1;
          end else begin
            items_nxt = items_r + 1'b1;
          end
          // advance the vote
          if (vote_r == '0) begin
            cand_nxt = in_ch.value;
            vote_nxt = mvc_pkg::count_t'(1);
          end else if (match_a) begin
            vote_nxt = vote_r + 1'b1;
          end else begin
            vote_nxt = vote_r - 1'b1;
          end
          if (in_ch.last) begin
            scan_nxt  = '0;
            hits_nxt  = '0;
            state_nxt = (ovf_r || full) ? mvc_pkg::ST_RESULT : mvc_pkg::ST_SCAN;
          end
        end
      end

      mvc_pkg::ST_SCAN: begin
        // count hits from the previous read
        if (rd_pend_r && match) begin
          hits_nxt = hits_r + 1'b1;
        end
        // issue the next read or finish once the pipe drains
        if (scan_r != items_r) begin
          scan_nxt    = scan_r + 1'b1;
          rd_pend_nxt = 1'b1;
        end else if (!rd_pend_r) begin
          state_nxt = mvc_pkg::ST_RESULT;
        end
      end

      mvc_pkg::ST_RESULT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (ovf_r) begin
            out_value_nxt  = '0;
            out_status_nxt = mvc_pkg::STATUS_OVERFLOW;
          end else if ({hits_r, 1'b0} > {1'b0, items_r}) begin
            out_value_nxt  = cand_r;
            out_status_nxt = mvc_pkg::STATUS_FOUND;
          end else begin
            out_value_nxt  = '0;
            out_status_nxt = mvc_pkg::STATUS_NONE;
          end
          // drop frame state
          cand_nxt  = '0;
          vote_nxt  = '0;
          items_nxt = '0;
          ovf_nxt   = 1'b0;
          state_nxt = mvc_pkg::ST_LOAD;
        end
      end

      default: begin
        state_nxt = mvc_pkg::ST_LOAD;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mvc_pkg::ST_LOAD;
      cand_r      <= '0;
      vote_r      <= '0;
      items_r     <= '0;
      ovf_r       <= 1'b0;
      scan_r      <= '0;
      rd_pend_r   <= 1'b0;
      hits_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cand_r      <= cand_nxt;
      vote_r      <= vote_nxt;
      items_r     <= items_nxt;
      ovf_r       <= ovf_nxt;
      scan_r      <= scan_nxt;
      rd_pend_r   <= rd_pend_nxt;
      hits_r      <= hits_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
  end

endmodule
